### src/snell_refraction_vector_unit_macros.svh
// Assertion macros shared by the refraction unit.
`ifndef SNELL_REFRACTION_VECTOR_UNIT_MACROS_SVH
`define SNELL_REFRACTION_VECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on aclk with reset masked.
`define SRV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("srv check failed");

// Next-cycle implication, checked on aclk with reset masked.
`define SRV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("srv check failed");

`endif

### src/srv_pkg.sv
package srv_pkg;

    localparam int VW      = 16;
    localparam int DQ_W    = 19;
    localparam int DSQ_W   = 38;
    localparam int OM_W    = 24;
    localparam int RR_W    = 32;
    localparam int PROD_W  = 57;
    localparam int SQ_IN_W = 46;
    localparam int SQ_W    = SQ_IN_W / 2;
    localparam int FRONT_STAGES = 6;

    // Operands that ride alongside the discriminant and square root stages.
    typedef struct packed {
        logic signed [VW-1:0]   vx;
        logic signed [VW-1:0]   vy;
        logic signed [VW-1:0]   vz;
        logic signed [VW-1:0]   nx;
        logic signed [VW-1:0]   ny;
        logic signed [VW-1:0]   nz;
        logic [VW-1:0]          r;
        logic signed [DQ_W-1:0] dq;
        logic                   pos;
    } srv_side_t;

endpackage

### src/srv_front.sv
module srv_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic signed [srv_pkg::VW-1:0]  vx,
    input  logic signed [srv_pkg::VW-1:0]  vy,
    input  logic signed [srv_pkg::VW-1:0]  vz,
    input  logic signed [srv_pkg::VW-1:0]  nx,
    input  logic signed [srv_pkg::VW-1:0]  ny,
    input  logic signed [srv_pkg::VW-1:0]  nz,
    input  logic [srv_pkg::VW-1:0]         r,
    output logic                           out_vld,
    output logic [srv_pkg::SQ_IN_W-1:0]    out_disc,
    output srv_pkg::srv_side_t             out_side
);

    logic [srv_pkg::FRONT_STAGES-1:0] vld_reg;
    srv_pkg::srv_side_t sd1_reg, sd2_reg, sd3_reg, sd4_reg, sd5_reg, sd6_reg;
    srv_pkg::srv_side_t sd1_next, sd2_next, sd6_next;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [srv_pkg::RR_W-1:0] rr1_reg, rr2_reg, rr3_reg, rr4_reg;
    logic signed [srv_pkg::DSQ_W-1:0] dsq_reg;
    logic signed [srv_pkg::OM_W-1:0] om14_reg;
    logic signed [srv_pkg::PROD_W-1:0] prod_reg;
    logic [srv_pkg::SQ_IN_W-1:0] disc_reg;
    logic [srv_pkg::SQ_IN_W-1:0] disc_next;

    logic signed [33:0] d28;
    logic signed [33:0] dq_full;
    logic signed [38:0] om;
    logic signed [38:0] om_rnd;
    logic signed [srv_pkg::PROD_W-1:0] prod_rnd;
    logic signed [srv_pkg::PROD_W:0] disc_full;

    always_comb begin
        sd1_next     = '0;
        sd1_next.vx  = vx;
        sd1_next.vy  = vy;
        sd1_next.vz  = vz;
        sd1_next.nx  = nx;
        sd1_next.ny  = ny;
        sd1_next.nz  = nz;
        sd1_next.r   = r;

        d28 = 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
        dq_full = (d28 + 34'sd8192) >>> 14;
        sd2_next = sd1_reg;
        sd2_next.dq = dq_full[srv_pkg::DQ_W-1:0];

        om = 39'sd268435456 - 39'(dsq_reg);
        om_rnd = (om + 39'sd8192) >>> 14;

        prod_rnd = (prod_reg + 57'sd512) >>> 10;
        disc_full = 58'sd268435456 - 58'(prod_rnd);
        sd6_next = sd5_reg;
        sd6_next.pos = (disc_full > 58'sd0);
        disc_next = sd6_next.pos ? disc_full[srv_pkg::SQ_IN_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[srv_pkg::FRONT_STAGES-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= vx * nx;
            py_reg   <= vy * ny;
            pz_reg   <= vz * nz;
            rr1_reg  <= r * r;
            sd1_reg  <= sd1_next;

            sd2_reg  <= sd2_next;
            rr2_reg  <= rr1_reg;

            dsq_reg  <= sd2_reg.dq * sd2_reg.dq;
            rr3_reg  <= rr2_reg;
            sd3_reg  <= sd2_reg;

            om14_reg <= om_rnd[srv_pkg::OM_W-1:0];
            rr4_reg  <= rr3_reg;
            sd4_reg  <= sd3_reg;

            prod_reg <= $signed({1'b0, rr4_reg}) * om14_reg;
            sd5_reg  <= sd4_reg;

            disc_reg <= disc_next;
            sd6_reg  <= sd6_next;
        end
    end

    assign out_vld  = vld_reg[srv_pkg::FRONT_STAGES-1];
    assign out_disc = disc_reg;
    assign out_side = sd6_reg;

endmodule

### src/srv_sqrt.sv
module srv_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [srv_pkg::SQ_IN_W-1:0]   in_x,
    input  srv_pkg::srv_side_t            in_side,
    output logic                          out_vld,
    output logic [srv_pkg::SQ_W-1:0]      out_root,
    output srv_pkg::srv_side_t            out_side
);

    localparam int N = srv_pkg::SQ_W;
    localparam int XW = srv_pkg::SQ_IN_W;

    logic [N-1:0]  vld_reg;
    logic [XW-1:0] x_reg   [N];
    logic [XW-1:0] res_reg [N];
    srv_pkg::srv_side_t sd_reg [N];

    // One result bit per stage, restoring method, most significant bit first.
    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (N - 1 - k));
        logic [XW-1:0] x_in, res_in, x_next, res_next;
        logic [XW:0]   trial;
        logic          vld_in;
        srv_pkg::srv_side_t sd_in;

        if (k == 0) begin : g_first
            assign x_in   = in_x;
            assign res_in = '0;
            assign vld_in = in_vld;
            assign sd_in  = in_side;
        end else begin : g_rest
            assign x_in   = x_reg[k-1];
            assign res_in = res_reg[k-1];
            assign vld_in = vld_reg[k-1];
            assign sd_in  = sd_reg[k-1];
        end

        always_comb begin
            trial = {1'b0, res_in} + {1'b0, BIT};
            if ({1'b0, x_in} >= trial) begin
                x_next   = x_in - trial[XW-1:0];
                res_next = (res_in >> 1) + BIT;
            end else begin
                x_next   = x_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]   <= x_next;
                res_reg[k] <= res_next;
                sd_reg[k]  <= sd_in;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_root = res_reg[N-1][N-1:0];
    assign out_side = sd_reg[N-1];

endmodule

### src/srv_back.sv
module srv_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [srv_pkg::SQ_W-1:0]      in_root,
    input  srv_pkg::srv_side_t            in_side,
    output logic                          out_vld,
    output logic signed [srv_pkg::VW-1:0] ref_x,
    output logic signed [srv_pkg::VW-1:0] ref_y,
    output logic signed [srv_pkg::VW-1:0] ref_z,
    output logic                          refracts
);

    logic [2:0] vld_reg;
    logic signed [srv_pkg::VW-1:0] v_in [3];
    logic signed [srv_pkg::VW-1:0] n_in [3];

    logic signed [35:0] tang_reg [3];
    logic signed [39:0] nsq1_reg [3];
    logic signed [39:0] nsq2_reg [3];
    logic signed [52:0] a_reg    [3];
    logic [srv_pkg::VW-1:0] r1_reg;
    logic pos1_reg, pos2_reg;
    logic signed [srv_pkg::VW-1:0] o_reg [3];
    logic signed [srv_pkg::VW-1:0] o_next [3];
    logic refracts_reg;

    assign v_in[0] = in_side.vx;
    assign v_in[1] = in_side.vy;
    assign v_in[2] = in_side.vz;
    assign n_in[0] = in_side.nx;
    assign n_in[1] = in_side.ny;
    assign n_in[2] = in_side.nz;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic signed [35:0] tang_next;
        logic signed [39:0] nsq_next;
        logic signed [54:0] acc;
        logic signed [54:0] rnd;

        always_comb begin
            tang_next = (36'(v_in[i]) <<< 14) - 36'(n_in[i]) * 36'(in_side.dq);
            nsq_next  = n_in[i] * $signed({1'b0, in_root});
            acc = 55'(a_reg[i]) - (55'(nsq2_reg[i]) <<< 12);
            rnd = (acc + 55'sd33554432) >>> 26;
            if (!pos2_reg) begin
                o_next[i] = '0;
            end else if (rnd > 55'sd32767) begin
                o_next[i] = 16'sh7FFF;
            end else if (rnd < -55'sd32768) begin
                o_next[i] = 16'sh8000;
            end else begin
                o_next[i] = rnd[srv_pkg::VW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tang_reg[i] <= tang_next;
                nsq1_reg[i] <= nsq_next;
                a_reg[i]    <= $signed({1'b0, r1_reg}) * tang_reg[i];
                nsq2_reg[i] <= nsq1_reg[i];
                o_reg[i]    <= o_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg       <= in_side.r;
            pos1_reg     <= in_side.pos;
            pos2_reg     <= pos1_reg;
            refracts_reg <= pos2_reg;
        end
    end

    assign out_vld  = vld_reg[2];
    assign ref_x    = o_reg[0];
    assign ref_y    = o_reg[1];
    assign ref_z    = o_reg[2];
    assign refracts = refracts_reg;

endmodule

### src/snell_refraction_vector_unit.sv
// Snell refraction unit: for each item (unit direction v, unit normal n in signed Q2.14,
// index ratio r in unsigned Q4.12) it returns r(v - n d) - n sqrt(disc), with d = v.n and
// disc = 1 - r^2(1 - d^2), saturated to Q2.14 with refracts set; when disc is zero or
// negative (total internal reflection) it returns a zero vector with refracts clear.
// The unit is fully pipelined and accepts one item every clock cycle. From acceptance to the
// result appearing on the m_ side, six stages form the discriminant, the square root takes
// one stage per result bit (23 stages), and three stages form and saturate the refracted
// vector. The whole pipeline advances together; it halts only while a result waits on the
// output with m_ready low.
`include "snell_refraction_vector_unit_macros.svh"

module snell_refraction_vector_unit (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [srv_pkg::VW-1:0] s_dir_x,
    input  logic signed [srv_pkg::VW-1:0] s_dir_y,
    input  logic signed [srv_pkg::VW-1:0] s_dir_z,
    input  logic signed [srv_pkg::VW-1:0] s_norm_x,
    input  logic signed [srv_pkg::VW-1:0] s_norm_y,
    input  logic signed [srv_pkg::VW-1:0] s_norm_z,
    input  logic [srv_pkg::VW-1:0]        s_index_ratio,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [srv_pkg::VW-1:0] m_ref_x,
    output logic signed [srv_pkg::VW-1:0] m_ref_y,
    output logic signed [srv_pkg::VW-1:0] m_ref_z,
    output logic                          m_refracts
);

    // Pipeline advance: every stage moves unless a finished item is held at the output.
    logic en;

    logic                          fr_vld;
    logic [srv_pkg::SQ_IN_W-1:0]   fr_disc;
    srv_pkg::srv_side_t            fr_side;

    logic                          sq_vld;
    logic [srv_pkg::SQ_W-1:0]      sq_root;
    srv_pkg::srv_side_t            sq_side;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Dot product, 1 - d^2 and the discriminant.
    srv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid && s_ready),
        .vx       (s_dir_x),
        .vy       (s_dir_y),
        .vz       (s_dir_z),
        .nx       (s_norm_x),
        .ny       (s_norm_y),
        .nz       (s_norm_z),
        .r        (s_index_ratio),
        .out_vld  (fr_vld),
        .out_disc (fr_disc),
        .out_side (fr_side)
    );

    // Integer square root of the discriminant, one result bit per stage.
    srv_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (fr_vld),
        .in_x     (fr_disc),
        .in_side  (fr_side),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // Tangential term, normal term, rounding and saturation; ends in the output register.
    srv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (sq_vld),
        .in_root  (sq_root),
        .in_side  (sq_side),
        .out_vld  (m_valid),
        .ref_x    (m_ref_x),
        .ref_y    (m_ref_y),
        .ref_z    (m_ref_z),
        .refracts (m_refracts)
    );

    // A reflected item always carries a zero vector.
    `SRV_ASSERT_SAME(a_tir_zero, m_valid && !m_refracts, m_ref_x == 0 && m_ref_y == 0 && m_ref_z == 0)
    // A held result blocks new items.
    `SRV_ASSERT_SAME(a_stall_blocks, m_valid && !m_ready, !s_ready)
    // An accepted item shows up in the first pipeline stage.
    `SRV_ASSERT_NEXT(a_enter, s_valid && s_ready, u_front.vld_reg[0])
    // A valid item that does not refract reaches the square root stages with a zero discriminant.
    `SRV_ASSERT_SAME(a_disc_pos, fr_vld && !fr_side.pos, fr_disc == 0)

endmodule
